// File: hdl/imufd_pkg.sv
// Shared types and constants for the IMU FIFO word decompressor.
// No dependencies; imported by the front end, the queue and the back end.
package imufd_pkg;

  // What a FIFO word turns into
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_PLAIN = 2'd1,
    KIND_2X    = 2'd2,
    KIND_3X    = 2'd3
  } kind_t;

  // Sensor index into the base store
  localparam logic IDX_GYRO  = 1'b0;
  localparam logic IDX_ACCEL = 1'b1;

  // Tag codes, tag bits 7:3
  localparam logic [4:0] TAG_GYRO_A   = 5'h01;
  localparam logic [4:0] TAG_GYRO_B   = 5'h06;
  localparam logic [4:0] TAG_GYRO_C   = 5'h07;
  localparam logic [4:0] TAG_GYRO_2X  = 5'h08;
  localparam logic [4:0] TAG_GYRO_3X  = 5'h09;
  localparam logic [4:0] TAG_ACCEL_A  = 5'h02;
  localparam logic [4:0] TAG_ACCEL_B  = 5'h0A;
  localparam logic [4:0] TAG_ACCEL_C  = 5'h0B;
  localparam logic [4:0] TAG_ACCEL_2X = 5'h0C;
  localparam logic [4:0] TAG_ACCEL_3X = 5'h0D;

  // Classified word as it travels from front end to back end
  typedef struct packed {
    logic [7:0]      tag;
    logic            sensor;
    kind_t           kind;
    logic [5:0][7:0] bytes;
  } cmd_t;

endpackage

// File: hdl/imufd_front.sv
// Front end: accepts FIFO words, decodes the tag and pushes known words
// into the command queue. Depends on imufd_pkg.
module imufd_front
  import imufd_pkg::*;
(
  input  logic       word_valid,
  output logic       word_ready,
  input  logic [7:0] raw_tag,
  input  logic [7:0] data_byte0,
  input  logic [7:0] data_byte1,
  input  logic [7:0] data_byte2,
  input  logic [7:0] data_byte3,
  input  logic [7:0] data_byte4,
  input  logic [7:0] data_byte5,
  input  logic       queue_full,
  output logic       push,
  output cmd_t       cmd
);

  logic [4:0] code;
  logic       sensor;
  kind_t      kind;

  // Tag decode
  always_comb begin
    code   = raw_tag[7:3];
    sensor = IDX_GYRO;
    kind   = KIND_NONE;
    case (code)
      TAG_GYRO_A, TAG_GYRO_B, TAG_GYRO_C: begin
        kind = KIND_PLAIN;
      end
      TAG_GYRO_2X: kind = KIND_2X;
      TAG_GYRO_3X: kind = KIND_3X;
      TAG_ACCEL_A, TAG_ACCEL_B, TAG_ACCEL_C: begin
        sensor = IDX_ACCEL;
        kind   = KIND_PLAIN;
      end
      TAG_ACCEL_2X: begin
        sensor = IDX_ACCEL;
        kind   = KIND_2X;
      end
      TAG_ACCEL_3X: begin
        sensor = IDX_ACCEL;
        kind   = KIND_3X;
      end
      default: begin
        sensor = IDX_GYRO;
        kind   = KIND_NONE;
      end
    endcase
  end

  // Unknown tags are taken and dropped here; they never reach the queue
  assign word_ready = !queue_full;
  assign push       = word_valid && !queue_full && (kind != KIND_NONE);

  always_comb begin
    cmd.tag    = raw_tag;
    cmd.sensor = sensor;
    cmd.kind   = kind;
    cmd.bytes  = {data_byte5, data_byte4, data_byte3, data_byte2, data_byte1, data_byte0};
  end

endmodule

// File: hdl/imufd_queue.sv
// Small command queue between front end and back end.
// Depends on imufd_pkg for the command type.
module imufd_queue
  import imufd_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  cmd_t            mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full       = (count == CntFull);
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hdl/imufd_back.sv
// Back end: holds the per-sensor base samples, expands the queue head into one
// sample per cycle unless the output stalls, and drives the registered sample port. Uses imufd_pkg.
module imufd_back
  import imufd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  cmd_t        head,
  output logic        pop,
  output logic        sample_valid,
  input  logic        sample_ready,
  output logic [7:0]  sample_tag,
  output logic [15:0] sample_x,
  output logic [15:0] sample_y,
  output logic [15:0] sample_z,
  output logic        last_of_word
);

  logic [47:0] base_sample [2];
  logic [1:0]  base_valid;
  logic [1:0]  step;
  logic [1:0]  step_next;

  logic        compressed;
  logic        no_base;
  logic        last_step;
  logic        can_emit;
  logic        emit;
  logic [15:0] packed_word;
  logic [15:0] dx;
  logic [15:0] dy;
  logic [15:0] dz;
  logic [47:0] base_cur;
  logic [47:0] new_sample;

  assign compressed = (head.kind == KIND_2X) || (head.kind == KIND_3X);
  assign no_base    = compressed && !base_valid[head.sensor];
  assign can_emit   = !sample_valid || sample_ready;
  assign last_step  = (head.kind == KIND_PLAIN) ||
                      ((head.kind == KIND_2X) && (step == 2'd1)) ||
                      ((head.kind == KIND_3X) && (step == 2'd2));
  assign emit       = head_valid && !no_base && can_emit;
  assign pop        = head_valid && (no_base || (emit && last_step));
  assign step_next  = last_step ? 2'd0 : step + 2'd1;
  assign base_cur   = base_sample[head.sensor];

  // Pick the 3x packed word for this step
  always_comb begin
    case (step)
      2'd0:    packed_word = {head.bytes[1], head.bytes[0]};
      2'd1:    packed_word = {head.bytes[3], head.bytes[2]};
      2'd2:    packed_word = {head.bytes[5], head.bytes[4]};
      default: packed_word = {head.bytes[1], head.bytes[0]};
    endcase
  end

  // Delta triple for this step, sign extended to 16 bits
  always_comb begin
    if (head.kind == KIND_2X) begin
      if (step == 2'd0) begin
        dx = {{8{head.bytes[0][7]}}, head.bytes[0]};
        dy = {{8{head.bytes[1][7]}}, head.bytes[1]};
        dz = {{8{head.bytes[2][7]}}, head.bytes[2]};
      end else begin
        dx = {{8{head.bytes[3][7]}}, head.bytes[3]};
        dy = {{8{head.bytes[4][7]}}, head.bytes[4]};
        dz = {{8{head.bytes[5][7]}}, head.bytes[5]};
      end
    end else begin
      dx = {{11{packed_word[4]}},  packed_word[4:0]};
      dy = {{11{packed_word[9]}},  packed_word[9:5]};
      dz = {{11{packed_word[14]}}, packed_word[14:10]};
    end
  end

  // New sample: plain payload or running sum, wrapping at 16 bits
  always_comb begin
    if (head.kind == KIND_PLAIN) begin
      new_sample = {head.bytes[5], head.bytes[4], head.bytes[3],
                    head.bytes[2], head.bytes[1], head.bytes[0]};
    end else begin
      new_sample = {base_cur[47:32] + dz, base_cur[31:16] + dy, base_cur[15:0] + dx};
    end
  end

  // Base store; the newest emitted sample always becomes the base
  always_ff @(posedge clk) begin
    if (emit) begin
      base_sample[head.sensor] <= new_sample;
    end
  end

  // Control: valid flags, step counter, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      base_valid   <= '0;
      step         <= '0;
      sample_valid <= 1'b0;
    end else begin
      if (emit) begin
        step <= step_next;
        if (head.kind == KIND_PLAIN) begin
          base_valid[head.sensor] <= 1'b1;
        end
      end
      if (emit) begin
        sample_valid <= 1'b1;
      end else if (sample_ready) begin
        sample_valid <= 1'b0;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (emit) begin
      sample_tag   <= head.tag;
      sample_x     <= new_sample[15:0];
      sample_y     <= new_sample[31:16];
      sample_z     <= new_sample[47:32];
      last_of_word <= last_step;
    end
  end

  // A step past the first belongs to a compressed word
  a_step_compressed: assert property (@(posedge clk) disable iff (rst)
    (head_valid && (step != 2'd0)) |-> compressed)
    else $error("step counter nonzero on a plain word");

  // The third step only exists for 3x words
  a_step_3x: assert property (@(posedge clk) disable iff (rst)
    (head_valid && (step == 2'd2)) |-> (head.kind == KIND_3X))
    else $error("third step on a non-3x word");

  // A word is dropped only at its first step
  a_drop_first: assert property (@(posedge clk) disable iff (rst)
    (pop && !emit) |-> (step == 2'd0))
    else $error("word dropped mid expansion");

  // A delta sample is only produced once the sensor has a base
  a_base_before_delta: assert property (@(posedge clk) disable iff (rst)
    (emit && compressed) |-> base_valid[head.sensor])
    else $error("delta sample without base");

endmodule

// File: hdl/imu_fifo_word_decompressor_unit.sv
// IMU FIFO word decompressor, top level.
// Instantiates imufd_front, imufd_queue and imufd_back; uses imufd_pkg.
//
// Takes one tagged FIFO word per handshake and emits zero to three xyz
// samples. Plain words give one sample and set the sensor's base; 2x and 3x
// words give two or three delta-reconstructed samples; unknown tags and
// compressed words before any plain word of that sensor give nothing. The
// front end decodes the tag and can take a word every cycle while the
// command queue (QUEUE_DEPTH entries) has room. The back end produces one
// sample per cycle, while the output is not stalled, into a registered
// output, so a plain word occupies it for one sample, a 2x word for two,
// a 3x word for three, and a dropped compressed word is popped with no
// sample; unknown tags skip it. The back end and output stalls set the rate.
module imu_fifo_word_decompressor_unit
  import imufd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        word_valid,
  output logic        word_ready,
  input  logic [7:0]  raw_tag,
  input  logic [7:0]  data_byte0,
  input  logic [7:0]  data_byte1,
  input  logic [7:0]  data_byte2,
  input  logic [7:0]  data_byte3,
  input  logic [7:0]  data_byte4,
  input  logic [7:0]  data_byte5,
  output logic        sample_valid,
  input  logic        sample_ready,
  output logic [7:0]  sample_tag,
  output logic [15:0] sample_x,
  output logic [15:0] sample_y,
  output logic [15:0] sample_z,
  output logic        last_of_word
);

  logic queue_full;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic head_valid;
  cmd_t head;

  imufd_front u_front (
    .word_valid (word_valid),
    .word_ready (word_ready),
    .raw_tag    (raw_tag),
    .data_byte0 (data_byte0),
    .data_byte1 (data_byte1),
    .data_byte2 (data_byte2),
    .data_byte3 (data_byte3),
    .data_byte4 (data_byte4),
    .data_byte5 (data_byte5),
    .queue_full (queue_full),
    .push       (push),
    .cmd        (push_cmd)
  );

  imufd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_cmd),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  imufd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_tag   (sample_tag),
    .sample_x     (sample_x),
    .sample_y     (sample_y),
    .sample_z     (sample_z),
    .last_of_word (last_of_word)
  );

endmodule
